/* src/jts_pkg.sv */
// Shared types, character codes and literal tables for the JSON token scanner.
// No dependencies; imported by the scanner core, result FIFO and top level.
package jts_pkg;

   localparam int DEF_OFFSET_BITS = 16;
   localparam int RESULT_DEPTH    = 4;

   // token kinds
   localparam logic [2:0] KIND_STRING = 3'd0;
   localparam logic [2:0] KIND_NUMBER = 3'd1;
   localparam logic [2:0] KIND_TRUE   = 3'd2;
   localparam logic [2:0] KIND_FALSE  = 3'd3;
   localparam logic [2:0] KIND_NULL   = 3'd4;

   // literal selectors
   localparam logic [1:0] LIT_TRUE  = 2'd0;
   localparam logic [1:0] LIT_FALSE = 2'd1;
   localparam logic [1:0] LIT_NULL  = 2'd2;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_DIGIT0 = 8'h30;
   localparam logic [7:0] CH_DIGIT9 = 8'h39;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_STR  = 4'b0010,
      MODE_NUM  = 4'b0100,
      MODE_LIT  = 4'b1000
   } scan_mode_type;

   typedef struct packed {
      logic push_a;   // token closed by the current scan state
      logic push_b;   // token raised by the byte handled afresh
   } push_ctrl_type;

   typedef struct packed {
      logic [2:0] level;
   } fifo_status_type;

   function automatic logic [2:0] lit_len(input logic [1:0] which);
      logic [2:0] len;
      case (which)
         LIT_TRUE:  len = 3'd4;
         LIT_FALSE: len = 3'd5;
         default:   len = 3'd4;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      case (which)
         LIT_TRUE: begin
            case (idx)
               3'd0:    ch = "t";
               3'd1:    ch = "r";
               3'd2:    ch = "u";
               3'd3:    ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LIT_FALSE: begin
            case (idx)
               3'd0:    ch = "f";
               3'd1:    ch = "a";
               3'd2:    ch = "l";
               3'd3:    ch = "s";
               3'd4:    ch = "e";
               default: ch = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    ch = "n";
               3'd1:    ch = "u";
               3'd2:    ch = "l";
               3'd3:    ch = "l";
               default: ch = 8'h00;
            endcase
         end
      endcase
      return ch;
   endfunction

endpackage

/* src/jts_if.sv */
// Valid/ready channel interfaces for text bytes in and token records out.
// Depends on jts_pkg for the default offset width.
interface jts_req_if
   import jts_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
);
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface jts_rsp_if
   import jts_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
);
   logic                   valid;
   logic                   ready;
   logic [2:0]             token_kind;
   logic                   key_flag;
   logic [OFFSET_BITS-1:0] start_offset;
   logic [OFFSET_BITS-1:0] token_length;
   logic                   unterminated;
   logic                   last_of_run;

   modport source (output valid, token_kind, key_flag, start_offset, token_length,
                   unterminated, last_of_run, input ready);
   modport sink   (input valid, token_kind, key_flag, start_offset, token_length,
                   unterminated, last_of_run, output ready);
endinterface

/* src/jts_scan_core.sv */
// Input stage register and scanner state; one byte is scanned per cycle while the
// result queue has room, and up to two token records are produced. Depends on jts_pkg.
module jts_scan_core
   import jts_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int ENTRY_W     = 2 * OFFSET_BITS + 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_byte,
   input  logic               in_eot,
   input  logic               space_ok,
   output logic               stage_valid,
   output push_ctrl_type      push,
   output logic [ENTRY_W-1:0] entry_a,
   output logic [ENTRY_W-1:0] entry_b
);

   localparam logic [OFFSET_BITS-1:0] OFS_ONE = OFFSET_BITS'(1);

   logic                   stage_valid_ff;
   logic [7:0]             byte_ff;
   logic                   eot_ff;
   logic                   proceed;

   scan_mode_type          mode_ff, mode_in;
   logic [1:0]             which_ff, which_in;
   logic [2:0]             matched_ff, matched_in;
   logic                   key_ff, key_in;
   logic                   pbs_ff, pbs_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] cnt_ff, cnt_in;

   logic                   a_valid, b_valid;
   logic [2:0]             a_kind, b_kind;
   logic [OFFSET_BITS-1:0] a_start, a_len, b_start, b_len;
   logic                   a_unterm, b_unterm;
   logic                   fresh;
   logic                   is_digit, is_num_char;
   logic [1:0]             lit_w;
   logic [2:0]             lit_n, lit_m;
   logic [OFFSET_BITS-1:0] cnt_sat;

   assign proceed     = stage_valid_ff && space_ok;
   assign in_ready    = !stage_valid_ff || proceed;
   assign stage_valid = stage_valid_ff;

   assign is_digit    = (byte_ff >= CH_DIGIT0) && (byte_ff <= CH_DIGIT9);
   assign is_num_char = is_digit || byte_ff == CH_PLUS || byte_ff == CH_MINUS
                        || byte_ff == CH_LOW_E || byte_ff == CH_UP_E || byte_ff == CH_DOT;
   assign lit_w       = (which_ff > LIT_NULL) ? LIT_NULL : which_ff;
   assign lit_n       = lit_len(lit_w);
   assign lit_m       = (matched_ff < lit_n) ? matched_ff : lit_n - 3'd1;
   assign cnt_sat     = (cnt_ff != '1) ? cnt_ff + OFS_ONE : cnt_ff;

   always_comb begin
      mode_in    = mode_ff;
      which_in   = which_ff;
      matched_in = matched_ff;
      key_in     = key_ff;
      pbs_in     = pbs_ff;
      start_in   = start_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff + OFS_ONE;
      a_valid    = 1'b0;
      a_kind     = KIND_STRING;
      a_start    = start_ff;
      a_len      = cnt_ff;
      a_unterm   = 1'b0;
      b_valid    = 1'b0;
      b_kind     = KIND_STRING;
      b_start    = pos_ff;
      b_len      = '0;
      b_unterm   = 1'b0;
      fresh      = 1'b0;

      case (mode_ff)
         MODE_STR: begin
            if (byte_ff == CH_QUOTE && !pbs_ff) begin
               a_valid = (cnt_ff != '0);
               mode_in = MODE_IDLE;
            end else begin
               cnt_in   = cnt_sat;
               pbs_in   = (byte_ff == CH_BSLASH);
               a_valid  = eot_ff;
               a_len    = cnt_sat;
               a_unterm = 1'b1;
            end
         end
         MODE_NUM: begin
            a_kind = KIND_NUMBER;
            if (is_num_char) begin
               cnt_in  = cnt_sat;
               a_len   = cnt_sat;
               a_valid = eot_ff;
            end else begin
               a_valid = 1'b1;
               mode_in = MODE_IDLE;
               fresh   = 1'b1;
            end
         end
         MODE_LIT: begin
            if (byte_ff == lit_char(lit_w, lit_m)) begin
               matched_in = lit_m + 3'd1;
               if (lit_m + 3'd1 == lit_n) begin
                  a_valid    = 1'b1;
                  a_kind     = KIND_TRUE + {1'b0, lit_w};
                  a_len      = {{(OFFSET_BITS-3){1'b0}}, lit_n};
                  mode_in    = MODE_IDLE;
                  matched_in = 3'd0;
               end
            end else begin
               mode_in    = MODE_IDLE;
               matched_in = 3'd0;
               fresh      = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      if (fresh) begin
         if (byte_ff == CH_LBRACE || byte_ff == CH_COMMA) begin
            key_in = 1'b1;
         end else if (byte_ff == CH_COLON || byte_ff == CH_LBRACK) begin
            key_in = 1'b0;
         end
         if (byte_ff == CH_QUOTE) begin
            start_in = pos_ff + OFS_ONE;
            cnt_in   = '0;
            pbs_in   = 1'b0;
            b_valid  = eot_ff;
            b_start  = pos_ff + OFS_ONE;
            b_unterm = 1'b1;
            if (!eot_ff) mode_in = MODE_STR;
         end else if (is_digit) begin
            start_in = pos_ff;
            cnt_in   = OFS_ONE;
            b_valid  = eot_ff;
            b_kind   = KIND_NUMBER;
            b_len    = OFS_ONE;
            if (!eot_ff) mode_in = MODE_NUM;
         end else if (byte_ff == CH_LOW_T || byte_ff == CH_LOW_F || byte_ff == CH_LOW_N) begin
            which_in   = (byte_ff == CH_LOW_T) ? LIT_TRUE :
                         (byte_ff == CH_LOW_F) ? LIT_FALSE : LIT_NULL;
            matched_in = 3'd1;
            start_in   = pos_ff;
            if (!eot_ff) mode_in = MODE_LIT;
         end
      end

      // end of document: everything but the key flag returns to reset
      if (eot_ff) begin
         mode_in    = MODE_IDLE;
         which_in   = 2'd0;
         matched_in = 3'd0;
         pbs_in     = 1'b0;
         pos_in     = '0;
         start_in   = '0;
         cnt_in     = '0;
      end
   end

   // A is ahead of B in the stream; the later of the two carries last_of_run
   assign entry_a     = {a_kind, key_ff, a_start, a_len, a_unterm, !b_valid};
   assign entry_b     = {b_kind, key_in, b_start, b_len, b_unterm, 1'b1};
   assign push.push_a = proceed && a_valid;
   assign push.push_b = proceed && b_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         mode_ff        <= MODE_IDLE;
         which_ff       <= 2'd0;
         matched_ff     <= 3'd0;
         key_ff         <= 1'b0;
         pbs_ff         <= 1'b0;
         pos_ff         <= '0;
         start_ff       <= '0;
         cnt_ff         <= '0;
      end else begin
         if (in_ready) stage_valid_ff <= in_valid;
         if (proceed) begin
            mode_ff    <= mode_in;
            which_ff   <= which_in;
            matched_ff <= matched_in;
            key_ff     <= key_in;
            pbs_ff     <= pbs_in;
            pos_ff     <= pos_in;
            start_ff   <= start_in;
            cnt_ff     <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         eot_ff  <= in_eot;
      end
   end

endmodule

/* src/jts_result_fifo.sv */
// Four-entry result queue with two write ports and one read port.
// Depends on jts_pkg for the push control and status types.
module jts_result_fifo
   import jts_pkg::*;
#(
   parameter int ENTRY_W = 2 * DEF_OFFSET_BITS + 6
) (
   input  logic               clock,
   input  logic               reset,
   input  push_ctrl_type      push,
   input  logic [ENTRY_W-1:0] entry_a,
   input  logic [ENTRY_W-1:0] entry_b,
   output logic               space_ok,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [ENTRY_W-1:0] out_entry,
   output fifo_status_type    status
);

   logic [ENTRY_W-1:0] mem [RESULT_DEPTH];
   logic [1:0]         wptr_ff, wptr_in;
   logic [1:0]         rptr_ff, rptr_in;
   logic [2:0]         level_ff, level_in;
   logic [1:0]         b_addr;
   logic               pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (level_ff != 3'd0);
   assign out_entry = mem[rptr_ff];
   // room for two beats whatever the read side does this cycle
   assign space_ok  = (level_ff <= 3'(RESULT_DEPTH - 2));
   assign status.level = level_ff;

   assign b_addr   = push.push_a ? wptr_ff + 2'd1 : wptr_ff;
   assign wptr_in  = wptr_ff + {1'b0, push.push_a} + {1'b0, push.push_b};
   assign rptr_in  = rptr_ff + {1'b0, pop};
   assign level_in = level_ff + {2'b0, push.push_a} + {2'b0, push.push_b} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 2'd0;
         rptr_ff  <= 2'd0;
         level_ff <= 3'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_a) mem[wptr_ff] <= entry_a;
      if (push.push_b) mem[b_addr]  <= entry_b;
   end

endmodule

/* src/json_token_scanner.sv */
// JSON token scanner: one text byte per cycle in, token records out.
// Path: an accepted byte waits in the input stage register until the queue has room,
// is scanned there, and its tokens are written into the queue and offered one at a time.
// Throughput: one byte per cycle while the queue holds two tokens or fewer; the
// input stalls while it holds three or four. Queue depth is four entries.
// Reset (synchronous, active high) returns scanner state, key flag and queue
// to empty.
module json_token_scanner
   import jts_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input logic   clock,
   input logic   reset,
   jts_req_if.sink   req_chan,
   jts_rsp_if.source rsp_chan
);

   localparam int ENTRY_W = 2 * OFFSET_BITS + 6;

   push_ctrl_type      push;
   fifo_status_type    status;
   logic [ENTRY_W-1:0] entry_a, entry_b, out_entry;
   logic               space_ok;
   logic               stage_valid;

   jts_scan_core #(
      .OFFSET_BITS (OFFSET_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_byte     (req_chan.text_byte),
      .in_eot      (req_chan.end_of_text),
      .space_ok    (space_ok),
      .stage_valid (stage_valid),
      .push        (push),
      .entry_a     (entry_a),
      .entry_b     (entry_b)
   );

   jts_result_fifo #(
      .ENTRY_W (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_a   (entry_a),
      .entry_b   (entry_b),
      .space_ok  (space_ok),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_entry (out_entry),
      .status    (status)
   );

   assign rsp_chan.token_kind   = out_entry[ENTRY_W-1 -: 3];
   assign rsp_chan.key_flag     = out_entry[ENTRY_W-4];
   assign rsp_chan.start_offset = out_entry[2*OFFSET_BITS+1 -: OFFSET_BITS];
   assign rsp_chan.token_length = out_entry[OFFSET_BITS+1 -: OFFSET_BITS];
   assign rsp_chan.unterminated = out_entry[1];
   assign rsp_chan.last_of_run  = out_entry[0];

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      status.level <= 3'(RESULT_DEPTH))
      else $error("result queue overfilled");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !push.push_a && !push.push_b)
      |=> status.level == $past(status.level) - 3'd1)
      else $error("result queue level wrong after a beat taken");

   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (stage_valid && !space_ok))
      else $error("input stalled with nothing blocking it");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.push_a || push.push_b) |-> status.level <= 3'(RESULT_DEPTH - 2))
      else $error("tokens pushed without room for them");

endmodule

/* bench/json_token_scanner_tb.sv */
// Self-checking bench for json_token_scanner: JSON byte stream in, token records out.
// Carries its own scanner model and checks each record in order.
// Needs jts_pkg, the jts_req_if/jts_rsp_if interfaces and the scanner RTL.
module json_token_scanner_tb
   import jts_pkg::*;
();

   localparam int OFS            = DEF_OFFSET_BITS;
   localparam int CLOCK_PERIOD   = 8;
   localparam int TIMEOUT_CYCLES = 2_000_000;
   localparam int LONG_CONTENT   = 200;   // well past any random token

   typedef struct packed {
      logic [2:0]     kind;
      logic           key;
      logic [OFS-1:0] start;
      logic [OFS-1:0] len;
      logic           unterm;
      logic           last;
   } token_rec_type;

   logic clock = 1'b0;
   logic reset;

   jts_req_if #(.OFFSET_BITS(OFS)) req_chan ();
   jts_rsp_if #(.OFFSET_BITS(OFS)) rsp_chan ();

   json_token_scanner #(.OFFSET_BITS(OFS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // scanner model state
   scan_mode_type  scan_state;
   logic [1:0]     lit_sel;
   logic [2:0]     lit_pos;
   logic           key_state;
   logic           esc_prev;
   logic [OFS-1:0] pos_count;
   logic [OFS-1:0] tok_begin;
   logic [OFS-1:0] tok_len;

   token_rec_type step_tokens[$];
   token_rec_type pending_tokens[$];
   logic [7:0] doc_bytes[$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int bytes_sent;
   int docs_sent;
   int tokens_seen;
   int strings_seen;
   int numbers_seen;
   int literals_seen;
   int cutoffs_seen;

   function automatic void note_token(input logic [2:0] kind, input logic [OFS-1:0] start,
                                      input logic [OFS-1:0] len, input logic unterm);
      token_rec_type t;
      t.kind   = kind;
      t.key    = key_state;
      t.start  = start;
      t.len    = len;
      t.unterm = unterm;
      t.last   = 1'b0;
      step_tokens.push_back(t);
   endfunction

   // a byte seen outside any token, or re-examined after a number closes or a literal fails
   function automatic void take_fresh(input logic [7:0] b, input logic eot);
      if (b == CH_LBRACE || b == CH_COMMA)
         key_state = 1'b1;
      else if (b == CH_COLON || b == CH_LBRACK)
         key_state = 1'b0;

      if (b == CH_QUOTE) begin
         tok_begin = pos_count + 1'b1;
         tok_len   = '0;
         esc_prev  = 1'b0;
         if (eot)
            note_token(KIND_STRING, tok_begin, '0, 1'b1);
         else
            scan_state = MODE_STR;
      end else if (b >= CH_DIGIT0 && b <= CH_DIGIT9) begin
         tok_begin = pos_count;
         tok_len   = OFS'(1);
         if (eot)
            note_token(KIND_NUMBER, tok_begin, tok_len, 1'b0);
         else
            scan_state = MODE_NUM;
      end else if (b == CH_LOW_T || b == CH_LOW_F || b == CH_LOW_N) begin
         lit_sel   = (b == CH_LOW_T) ? LIT_TRUE : (b == CH_LOW_F) ? LIT_FALSE : LIT_NULL;
         lit_pos   = 3'd1;
         tok_begin = pos_count;
         if (!eot)
            scan_state = MODE_LIT;
      end
   endfunction

   // model one accepted byte; its tokens go onto pending_tokens
   function automatic void scan_byte(input logic [7:0] b, input logic eot);
      logic        numeric;
      logic [39:0] word;
      logic [2:0]  lit_kind;
      int          want_len;
      int          idx;
      step_tokens.delete();
      numeric = (b >= CH_DIGIT0 && b <= CH_DIGIT9) || b == CH_PLUS || b == CH_MINUS ||
                b == CH_LOW_E || b == CH_UP_E || b == CH_DOT;
      case (scan_state)
         MODE_STR: begin
            if (b == CH_QUOTE && !esc_prev) begin
               if (tok_len != 0)
                  note_token(KIND_STRING, tok_begin, tok_len, 1'b0);
               scan_state = MODE_IDLE;
            end else begin
               if (tok_len != '1)
                  tok_len = tok_len + 1'b1;
               esc_prev = (b == CH_BSLASH);
               if (eot)
                  note_token(KIND_STRING, tok_begin, tok_len, 1'b1);
            end
         end
         MODE_NUM: begin
            if (numeric) begin
               if (tok_len != '1)
                  tok_len = tok_len + 1'b1;
               if (eot)
                  note_token(KIND_NUMBER, tok_begin, tok_len, 1'b0);
            end else begin
               note_token(KIND_NUMBER, tok_begin, tok_len, 1'b0);
               scan_state = MODE_IDLE;
               take_fresh(b, eot);
            end
         end
         MODE_LIT: begin
            case (lit_sel)
               LIT_TRUE: begin
                  word = "true";  want_len = 4; lit_kind = KIND_TRUE;
               end
               LIT_FALSE: begin
                  word = "false"; want_len = 5; lit_kind = KIND_FALSE;
               end
               default: begin
                  word = "null";  want_len = 4; lit_kind = KIND_NULL;
               end
            endcase
            idx = (lit_pos < want_len) ? int'(lit_pos) : want_len - 1;
            if (b == word[(want_len - 1 - idx) * 8 +: 8]) begin
               lit_pos = 3'(idx + 1);
               if (lit_pos == want_len) begin
                  note_token(lit_kind, tok_begin, OFS'(want_len), 1'b0);
                  scan_state = MODE_IDLE;
                  lit_pos    = '0;
               end
            end else begin
               scan_state = MODE_IDLE;
               lit_pos    = '0;
               take_fresh(b, eot);
            end
         end
         default: take_fresh(b, eot);
      endcase

      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i])
         pending_tokens.push_back(step_tokens[i]);

      pos_count = pos_count + 1'b1;
      // end of document clears everything but the key flag
      if (eot) begin
         scan_state = MODE_IDLE;
         lit_sel    = LIT_TRUE;
         lit_pos    = '0;
         esc_prev   = 1'b0;
         pos_count  = '0;
         tok_begin  = '0;
         tok_len    = '0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eot);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.text_byte   <= b;
      req_chan.end_of_text <= eot;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      scan_byte(b, eot);
      bytes_sent++;
   endtask

   task automatic send_document();
      foreach (doc_bytes[i])
         send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
      docs_sent++;
   endtask

   task automatic hold_off();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // ---- document builders ----
   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         doc_bytes.push_back(s[i]);
   endfunction

   function automatic void put_string_token();
      int         n;
      logic [7:0] c;
      n = $urandom_range(0, 6);   // zero gives an empty string
      doc_bytes.push_back(CH_QUOTE);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               doc_bytes.push_back(CH_BSLASH);
               doc_bytes.push_back(CH_QUOTE);
            end
            1: begin
               c = 8'($urandom_range(0, 255));
               doc_bytes.push_back(c == CH_QUOTE ? 8'h78 : c);
            end
            default: doc_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
         endcase
      end
      doc_bytes.push_back(CH_QUOTE);
   endfunction

   function automatic void put_number();
      string num_set = "0123456789+-eE.";
      doc_bytes.push_back(CH_DIGIT0 + 8'($urandom_range(0, 9)));
      repeat ($urandom_range(0, 5))
         doc_bytes.push_back(num_set[$urandom_range(0, num_set.len() - 1)]);
   endfunction

   function automatic void put_literal();
      string word;
      int    keep;
      case ($urandom_range(0, 2))
         0:       word = "true";
         1:       word = "false";
         default: word = "null";
      endcase
      keep = word.len();
      if ($urandom_range(0, 4) == 0)
         keep = $urandom_range(1, word.len() - 1);   // broken word
      for (int i = 0; i < keep; i++)
         doc_bytes.push_back(word[i]);
   endfunction

   function automatic void put_scalar();
      case ($urandom_range(0, 2))
         0:       put_string_token();
         1:       put_number();
         default: put_literal();
      endcase
   endfunction

   function automatic void put_value();
      case ($urandom_range(0, 7))
         6: begin
            doc_bytes.push_back(CH_LBRACK);
            put_scalar();
            doc_bytes.push_back(CH_COMMA);
            put_scalar();
            doc_bytes.push_back(8'h5D);
         end
         7: begin
            doc_bytes.push_back(8'($urandom_range(0, 255)));
            put_scalar();
         end
         default: put_scalar();
      endcase
   endfunction

   function automatic void build_document();
      int n;
      int cut;
      doc_bytes.delete();
      case ($urandom_range(0, 9))
         0: begin
            repeat ($urandom_range(1, 8))
               doc_bytes.push_back(8'($urandom_range(0, 255)));
         end
         1: put_scalar();
         2, 3, 4: begin
            doc_bytes.push_back(CH_LBRACK);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               if (i > 0)
                  doc_bytes.push_back(CH_COMMA);
               if ($urandom_range(0, 3) == 0)
                  doc_bytes.push_back(8'h20);
               put_value();
            end
            doc_bytes.push_back(8'h5D);
         end
         default: begin
            doc_bytes.push_back(CH_LBRACE);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               if (i > 0)
                  doc_bytes.push_back(CH_COMMA);
               put_string_token();
               doc_bytes.push_back(CH_COLON);
               put_value();
            end
            doc_bytes.push_back(8'h7D);
         end
      endcase
      // cut short so end of text lands inside a token now and then
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, doc_bytes.size());
         while (doc_bytes.size() > cut)
            void'(doc_bytes.pop_back());
      end
      if ($urandom_range(0, 7) == 0)
         doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
   endfunction

   // ---- tests ----
   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic test_directed_cases();
      // empty string, then a number closed by a quote on the final byte
      doc_bytes.delete();
      put_text("{\"\":7\"");
      send_document();
      // partial null dropped, mismatching byte starts false
      doc_bytes.delete();
      put_text(":nulfalse");
      send_document();
      // escaped quote, extreme byte values, then true cut off by end of text
      doc_bytes.delete();
      put_text(",\"\\\"");
      doc_bytes.push_back(8'hFF);
      doc_bytes.push_back(8'h00);
      put_text("\"tru");
      send_document();
   endtask

   task automatic test_random_documents(input int n_bytes);
      int first;
      first = bytes_sent;
      while (bytes_sent - first < n_bytes) begin
         build_document();
         send_document();
      end
   endtask

   task automatic test_drain_pause();
      build_document();
      send_document();
      hold_off();
      while (pending_tokens.size() != 0)
         @(posedge clock);
      build_document();
      send_document();
   endtask

   task automatic test_long_string();
      doc_bytes.delete();
      doc_bytes.push_back(CH_QUOTE);
      repeat (LONG_CONTENT)
         doc_bytes.push_back(8'h41 + 8'($urandom_range(0, 25)));
      doc_bytes.push_back(CH_QUOTE);
      doc_bytes.push_back(CH_DIGIT0 + 8'd5);
      send_document();
   endtask

   // result checker
   always @(posedge clock) begin
      token_rec_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         tokens_seen++;
         if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("token kind %0d with nothing expected",
                                      rsp_chan.token_kind));
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_chan.token_kind !== want.kind)
               report_mismatch($sformatf("token_kind %0d, want %0d",
                                         rsp_chan.token_kind, want.kind));
            if (rsp_chan.key_flag !== want.key)
               report_mismatch($sformatf("key_flag %0b, want %0b",
                                         rsp_chan.key_flag, want.key));
            if (rsp_chan.start_offset !== want.start)
               report_mismatch($sformatf("start_offset %0d, want %0d",
                                         rsp_chan.start_offset, want.start));
            if (rsp_chan.token_length !== want.len)
               report_mismatch($sformatf("token_length %0d, want %0d",
                                         rsp_chan.token_length, want.len));
            if (rsp_chan.unterminated !== want.unterm)
               report_mismatch($sformatf("unterminated %0b, want %0b",
                                         rsp_chan.unterminated, want.unterm));
            if (rsp_chan.last_of_run !== want.last)
               report_mismatch($sformatf("last_of_run %0b, want %0b",
                                         rsp_chan.last_of_run, want.last));
            case (want.kind)
               KIND_STRING: strings_seen++;
               KIND_NUMBER: numbers_seen++;
               default:     literals_seen++;
            endcase
            if (want.unterm)
               cutoffs_seen++;
         end
      end
   end

   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.text_byte   = 8'h00;
      req_chan.end_of_text = 1'b0;
      mismatches    = 0;
      bytes_sent    = 0;
      docs_sent     = 0;
      tokens_seen   = 0;
      strings_seen  = 0;
      numbers_seen  = 0;
      literals_seen = 0;
      cutoffs_seen  = 0;
      scan_state = MODE_IDLE;
      lit_sel    = LIT_TRUE;
      lit_pos    = '0;
      key_state  = 1'b0;
      esc_prev   = 1'b0;
      pos_count  = '0;
      tok_begin  = '0;
      tok_len    = '0;
      set_idling(0, 0);
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      set_idling(25, 78);
      test_directed_cases();
      test_random_documents(330);

      set_idling(78, 25);
      test_random_documents(330);
      test_drain_pause();

      set_idling(0, 0);
      test_random_documents(330);
      test_long_string();

      hold_off();
      while (pending_tokens.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Scanned %0d bytes in %0d documents under three idling mixes and a drain.",
               bytes_sent, docs_sent);
      $display("Tokens checked: %0d (%0d strings, %0d numbers, %0d literals, %0d cut off).",
               tokens_seen, strings_seen, numbers_seen, literals_seen, cutoffs_seen);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
src/jts_pkg.sv
src/jts_if.sv
src/jts_scan_core.sv
src/jts_result_fifo.sv
src/json_token_scanner.sv
bench/json_token_scanner_tb.sv
